// ===== design/julia_set_bitmap_engine_macros.svh =====
// Assertion macros shared by the Julia set bitmap engine.
`ifndef JULIA_SET_BITMAP_ENGINE_MACROS_SVH
`define JULIA_SET_BITMAP_ENGINE_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define JSBE_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define JSBE_ASSERT_NEXT(lbl, clk, rst_n, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// ===== design/jsbe_pkg.sv =====
// Package with types, constants and helpers of the Julia set bitmap engine.
`default_nettype none
package jsbe_pkg;

    localparam int FRAC_BITS = 28;
    localparam int NUM_W     = FRAC_BITS + 4;
    localparam int DIM_W     = 13;
    localparam int POS_W     = 12;
    localparam int MAG_W     = POS_W + 3;
    localparam int DIV_STEPS = MAG_W + FRAC_BITS;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int ITER_W    = 16;
    localparam int COUNT_W   = ITER_W + 1;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 32;

    typedef logic signed [NUM_W-1:0] t_fix;

    localparam t_fix LIM_HI = t_fix'({1'b0, {(NUM_W-1){1'b1}}});
    localparam t_fix LIM_LO = t_fix'({1'b1, {(NUM_W-1){1'b0}}});

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONST_RE = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CONST_IM = 8'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = 8'd4;

    localparam logic [DIM_W-1:0]  RST_WIDTH    = 13'd256;
    localparam logic [DIM_W-1:0]  RST_HEIGHT   = 13'd256;
    localparam logic [ITER_W-1:0] RST_MAX_ITER = 16'd100;

    typedef struct packed {
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
    } t_pixel_in;

    typedef struct packed {
        logic [7:0] packed_byte;
        logic       row_end;
    } t_byte_out;

    typedef struct packed {
        t_fix zr;
        t_fix zi;
        logic last;
    } t_queue_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_SAT,
        B_UPD,
        B_PACK
    } t_back_state;

    // Saturating sum of two values in the number format.
    function automatic t_fix sat_add(input t_fix a, input t_fix b);
        logic signed [NUM_W:0] s;
        s = {a[NUM_W-1], a} + {b[NUM_W-1], b};
        if (s[NUM_W] != s[NUM_W-1]) begin
            return s[NUM_W] ? LIM_LO : LIM_HI;
        end
        return s[NUM_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== design/julia_set_bitmap_engine.sv =====
// Top level of the Julia set bitmap engine: configuration registers and wiring.
//
//   Channel  Direction  Handshake                  Beat
//   in       input      i_in_valid / o_in_ready    one pixel position (col, row)
//   out      output     o_out_valid / i_out_ready  one packed byte with row_end
//   cfg      input      i_cfg_valid / o_cfg_ready  register index and data
//
// The front end takes a pixel in F_IDLE, runs the coordinate division in F_DIV and hands the
// result to the queue in F_PUSH, where it waits while the queue is full.
// The back end takes a pixel in B_IDLE, runs B_MUL, B_SAT and B_UPD once per iteration and
// packs the result bit in B_PACK; the slower side sets the sustained rate.
// A two-entry queue lets the front divide the next pixel while the back iterates.
// Reset is synchronous and clears the handshake state and the bit packer.
// A full output register holds the back end only when a byte must be emitted.
`default_nettype none
`include "julia_set_bitmap_engine_macros.svh"
module julia_set_bitmap_engine
    import jsbe_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire t_pixel_in            i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output t_byte_out                 o_out_data,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data
);

    logic [DIM_W-1:0]  r_width, r_height;
    t_fix              r_const_re, r_const_im;
    logic [ITER_W-1:0] r_max_iter;

    logic          q_push, q_pop;
    t_queue_entry  q_wr_data, q_rd_data;
    t_queue_status q_status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= RST_WIDTH;
            r_height   <= RST_HEIGHT;
            r_const_re <= '0;
            r_const_im <= '0;
            r_max_iter <= RST_MAX_ITER;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_WIDTH:    r_width    <= i_cfg_data[DIM_W-1:0];
                CFG_HEIGHT:   r_height   <= i_cfg_data[DIM_W-1:0];
                CFG_CONST_RE: r_const_re <= t_fix'(i_cfg_data);
                CFG_CONST_IM: r_const_im <= t_fix'(i_cfg_data);
                CFG_MAX_ITER: r_max_iter <= i_cfg_data[ITER_W-1:0];
                default: ;
            endcase
        end
    end

    jsbe_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_width    (r_width),
        .i_height   (r_height),
        .i_q_status (q_status),
        .o_q_push   (q_push),
        .o_q_data   (q_wr_data)
    );

    jsbe_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_data   (q_wr_data),
        .i_pop    (q_pop),
        .o_data   (q_rd_data),
        .o_status (q_status)
    );

    jsbe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_status  (q_status),
        .i_q_data    (q_rd_data),
        .o_q_pop     (q_pop),
        .i_const_re  (r_const_re),
        .i_const_im  (r_const_im),
        .i_max_iter  (r_max_iter),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    `JSBE_ASSERT_ALWAYS(a_no_push_full, i_clk, i_rst_n, !(q_push && q_status.full), "push into full queue")
    `JSBE_ASSERT_ALWAYS(a_no_pop_empty, i_clk, i_rst_n, !(q_pop && q_status.empty), "pop from empty queue")
    `JSBE_ASSERT_NEXT(a_busy_after_beat, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "front end not busy after a beat")

endmodule
`default_nettype wire

// ===== design/jsbe_front.sv =====
// Front end: accepts pixel positions and maps them to start points by long division.
`default_nettype none
module jsbe_front
    import jsbe_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire t_pixel_in     i_in_data,
    input  wire logic [DIM_W-1:0] i_width,
    input  wire logic [DIM_W-1:0] i_height,
    input  wire t_queue_status i_q_status,
    output logic               o_q_push,
    output t_queue_entry       o_q_data
);

    t_front_state r_state, n_state;

    logic [STEP_W-1:0]    r_step;
    logic [DIV_STEPS-1:0] r_dvd_re, r_dvd_im;
    logic [DIV_STEPS-1:0] r_quo_re, r_quo_im;
    logic [DIM_W-1:0]     r_rem_re, r_rem_im;
    logic [DIM_W-1:0]     r_den_re, r_den_im;
    logic                 r_neg_re, r_neg_im;
    logic                 r_last;

    logic [DIM_W-1:0]     w_eff, h_eff;
    logic signed [16:0]   num_re, num_im;
    logic [16:0]          mag_re, mag_im;
    logic                 accept;

    logic [DIM_W:0]       trial_re, trial_im;
    logic                 ge_re, ge_im;

    assign w_eff = (i_width  == '0) ? DIM_W'(1) : i_width;
    assign h_eff = (i_height == '0) ? DIM_W'(1) : i_height;

    assign num_re = $signed({3'b0, i_in_data.col, 2'b0}) + 17'sd4
                  - $signed({3'b0, w_eff, 1'b0});
    assign num_im = $signed({3'b0, h_eff, 1'b0}) - 17'sd4
                  - $signed({3'b0, i_in_data.row, 2'b0});
    assign mag_re = num_re[16] ? 17'(-num_re) : 17'(num_re);
    assign mag_im = num_im[16] ? 17'(-num_im) : 17'(num_im);

    assign accept = i_in_valid && o_in_ready;

    // One restoring division step per cycle on each coordinate.
    assign trial_re = {r_rem_re, r_dvd_re[DIV_STEPS-1]};
    assign trial_im = {r_rem_im, r_dvd_im[DIV_STEPS-1]};
    assign ge_re    = trial_re >= {1'b0, r_den_re};
    assign ge_im    = trial_im >= {1'b0, r_den_im};

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (accept) begin
                    n_state = F_DIV;
                end
            end
            F_DIV: begin
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_q_status.full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_q_push   = 1'b0;
        case (r_state)
            F_IDLE:  o_in_ready = 1'b1;
            F_PUSH:  o_q_push   = !i_q_status.full;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_step   <= '0;
            r_dvd_re <= {mag_re[MAG_W-1:0], {FRAC_BITS{1'b0}}};
            r_dvd_im <= {mag_im[MAG_W-1:0], {FRAC_BITS{1'b0}}};
            r_quo_re <= '0;
            r_quo_im <= '0;
            r_rem_re <= '0;
            r_rem_im <= '0;
            r_den_re <= w_eff;
            r_den_im <= h_eff;
            r_neg_re <= num_re[16];
            r_neg_im <= num_im[16];
            r_last   <= ({1'b0, i_in_data.col} == (w_eff - DIM_W'(1)));
        end else if (r_state == F_DIV) begin
            r_step   <= r_step + STEP_W'(1);
            r_dvd_re <= {r_dvd_re[DIV_STEPS-2:0], 1'b0};
            r_dvd_im <= {r_dvd_im[DIV_STEPS-2:0], 1'b0};
            r_quo_re <= {r_quo_re[DIV_STEPS-2:0], ge_re};
            r_quo_im <= {r_quo_im[DIV_STEPS-2:0], ge_im};
            r_rem_re <= ge_re ? DIM_W'(trial_re - {1'b0, r_den_re}) : trial_re[DIM_W-1:0];
            r_rem_im <= ge_im ? DIM_W'(trial_im - {1'b0, r_den_im}) : trial_im[DIM_W-1:0];
        end
    end

    // A quotient of eight or more saturates to the format limit.
    function automatic t_fix to_fix(input logic [DIV_STEPS-1:0] q, input logic neg);
        t_fix m;
        m = t_fix'({1'b0, q[NUM_W-2:0]});
        if (q[DIV_STEPS-1:NUM_W-1] != '0) begin
            return neg ? LIM_LO : LIM_HI;
        end
        return neg ? -m : m;
    endfunction

    always_comb begin
        o_q_data.zr   = to_fix(r_quo_re, r_neg_re);
        o_q_data.zi   = to_fix(r_quo_im, r_neg_im);
        o_q_data.last = r_last;
    end

endmodule
`default_nettype wire

// ===== design/jsbe_queue.sv =====
// Two-entry queue between the front end and the iteration back end.
`default_nettype none
module jsbe_queue
    import jsbe_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire t_queue_entry i_data,
    input  wire logic         i_pop,
    output t_queue_entry      o_data,
    output t_queue_status     o_status
);

    t_queue_entry r_mem [2];
    logic         r_wr_ptr, r_rd_ptr;
    logic [1:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data         = r_mem[r_rd_ptr];
    assign o_status.full  = r_count == 2'd2;
    assign o_status.empty = r_count == 2'd0;

endmodule
`default_nettype wire

// ===== design/jsbe_back.sv =====
// Back end: escape-time iteration, bit packing and the output register.
`default_nettype none
module jsbe_back
    import jsbe_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_queue_status     i_q_status,
    input  wire t_queue_entry      i_q_data,
    output logic                   o_q_pop,
    input  wire t_fix              i_const_re,
    input  wire t_fix              i_const_im,
    input  wire logic [ITER_W-1:0] i_max_iter,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output t_byte_out              o_out_data
);

    localparam logic [NUM_W:0] FOUR = (NUM_W+1)'(1) << (FRAC_BITS + 2);

    t_back_state r_state, n_state;

    t_fix               r_zr, r_zi, r_sr, r_si, r_p;
    logic               r_last, r_bit, r_neg_ri;
    logic [COUNT_W-1:0] r_count;
    logic [2*NUM_W-1:0] r_prod_rr, r_prod_ii, r_prod_ri;
    logic [7:0]         r_acc;
    logic [2:0]         r_bcnt;

    logic               done, pack_go, emit;
    logic [7:0]         acc_new;
    logic [3:0]         cnt_new;
    logic [NUM_W:0]     mag_sum;
    logic               over;

    function automatic logic [NUM_W-1:0] mag(input t_fix a);
        return a[NUM_W-1] ? NUM_W'(-a) : NUM_W'(a);
    endfunction

    function automatic t_fix sat_prod(input logic [2*NUM_W-1:0] prod, input logic neg);
        logic [2*NUM_W-1:0] sh;
        t_fix               m;
        sh = prod >> FRAC_BITS;
        m  = t_fix'(sh[NUM_W-1:0]);
        if (sh > (2*NUM_W)'(LIM_HI)) begin
            return neg ? LIM_LO : LIM_HI;
        end
        return neg ? -m : m;
    endfunction

    assign mag_sum = {1'b0, r_sr} + {1'b0, r_si};
    assign over    = r_count > {1'b0, i_max_iter};
    assign done    = over || (mag_sum >= FOUR);

    assign acc_new = {r_acc[6:0], r_bit};
    assign cnt_new = {1'b0, r_bcnt} + 4'd1;
    assign emit    = (cnt_new == 4'd8) || r_last;
    assign pack_go = !emit || !o_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (!i_q_status.empty) begin
                    n_state = B_MUL;
                end
            end
            B_MUL: n_state = B_SAT;
            B_SAT: n_state = B_UPD;
            B_UPD: n_state = done ? B_PACK : B_MUL;
            B_PACK: begin
                if (pack_go) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop = 1'b0;
        case (r_state)
            B_IDLE:  o_q_pop = !i_q_status.empty;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_acc       <= '0;
            r_bcnt      <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_out_valid && i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            if (r_state == B_PACK && pack_go) begin
                if (emit) begin
                    o_out_valid <= 1'b1;
                    r_acc       <= '0;
                    r_bcnt      <= '0;
                end else begin
                    r_acc  <= acc_new;
                    r_bcnt <= cnt_new[2:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_zr    <= i_q_data.zr;
                r_zi    <= i_q_data.zi;
                r_last  <= i_q_data.last;
                r_count <= '0;
            end
            B_MUL: begin
                r_prod_rr <= mag(r_zr) * mag(r_zr);
                r_prod_ii <= mag(r_zi) * mag(r_zi);
                r_prod_ri <= mag(r_zr) * mag(r_zi);
                r_neg_ri  <= r_zr[NUM_W-1] != r_zi[NUM_W-1];
            end
            B_SAT: begin
                r_sr <= sat_prod(r_prod_rr, 1'b0);
                r_si <= sat_prod(r_prod_ii, 1'b0);
                r_p  <= sat_prod(r_prod_ri, r_neg_ri);
            end
            B_UPD: begin
                if (done) begin
                    r_bit <= !over;
                end else begin
                    r_count <= r_count + COUNT_W'(1);
                    r_zr    <= sat_add(r_sr - r_si, i_const_re);
                    r_zi    <= sat_add(sat_add(r_p, r_p), i_const_im);
                end
            end
            default: ;
        endcase
    end

    // The partial byte of a row end is padded with zeros in its low bits.
    always_ff @(posedge i_clk) begin
        if (r_state == B_PACK && pack_go && emit) begin
            o_out_data.packed_byte <= 8'(acc_new << (4'd8 - cnt_new));
            o_out_data.row_end     <= r_last;
        end
    end

endmodule
`default_nettype wire
